// ===== rtl/mersenne_twister_generator_defines.svh =====
// Assertion macros shared by the RTL.
`ifndef MERSENNE_TWISTER_GENERATOR_DEFINES_SVH
`define MERSENNE_TWISTER_GENERATOR_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is held.
`define MT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled while reset is held.
`define MT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define MT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define MT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== rtl/mt_pkg.sv =====
`default_nettype none

package mt_pkg;

  localparam int N     = 624;
  localparam int M     = 397;
  localparam int IDX_W = 10;

  typedef logic [31:0]      word_t;
  typedef logic [IDX_W-1:0] idx_t;

  localparam idx_t LAST_IDX  = idx_t'(N - 1);
  localparam idx_t M_OFS     = idx_t'(M);
  localparam idx_t WRAP_OFS  = idx_t'(N - M);
  localparam idx_t IDX_DEPTH = idx_t'(N);

  localparam word_t SEED_MUL = 32'd1812433253;
  localparam word_t MATRIX_A = 32'h9908_B0DF;
  localparam word_t TEMPER_B = 32'h9D2C_5680;
  localparam word_t TEMPER_C = 32'hEFC6_0000;

  typedef enum logic [1:0] {
    ALU_SEED   = 2'd0,
    ALU_TWIST  = 2'd1,
    ALU_TEMPER = 2'd2
  } alu_op_t;

  // request to the shared arithmetic unit
  typedef struct packed {
    alu_op_t op;
    word_t   a;
    word_t   b;
    word_t   c;
    idx_t    idx;
  } alu_req_t;

  // state memory write port
  typedef struct packed {
    logic  en;
    idx_t  addr;
    word_t data;
  } ram_wr_t;

endpackage

`default_nettype wire

// ===== rtl/mt_ifs.sv =====
`default_nettype none

interface mt_in_if;
  import mt_pkg::*;
  logic  valid;
  logic  ready;
  logic  func;
  word_t seed_value;

  modport source (output valid, output func, output seed_value, input ready);
  modport sink   (input valid, input func, input seed_value, output ready);
endinterface

interface mt_out_if;
  import mt_pkg::*;
  logic  valid;
  logic  ready;
  word_t random_word;

  modport source (output valid, output random_word, input ready);
  modport sink   (input valid, input random_word, output ready);
endinterface

`default_nettype wire

// ===== rtl/mt_state_ram.sv =====
`default_nettype none

// 624 x 32 state store, one write and one registered read per cycle.
module mt_state_ram (
  input  wire              clk,
  input  mt_pkg::ram_wr_t  wr,
  input  mt_pkg::idx_t     raddr,
  output mt_pkg::word_t    rdata
);
  import mt_pkg::*;

  word_t mem [N];
  word_t rdata_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/mt_alu.sv =====
`default_nettype none

// Shared arithmetic unit: seed recurrence step, one-word twist, tempering.
module mt_alu (
  input  mt_pkg::alu_req_t req,
  output mt_pkg::word_t    res
);
  import mt_pkg::*;

  word_t x;
  word_t prod;
  word_t y;
  word_t t1;
  word_t t2;
  word_t t3;

  always_comb begin
    x    = req.a ^ (req.a >> 30);
    prod = x * SEED_MUL;
    // top bit of word k, low 31 bits of word k+1
    y    = {req.a[31], req.b[30:0]};
    t1   = req.a ^ (req.a >> 11);
    t2   = t1 ^ ((t1 << 7) & TEMPER_B);
    t3   = t2 ^ ((t2 << 15) & TEMPER_C);
    case (req.op)
      ALU_SEED:   res = prod + {{(32-IDX_W){1'b0}}, req.idx};
      ALU_TWIST:  res = req.c ^ (y >> 1) ^ (y[0] ? MATRIX_A : '0);
      ALU_TEMPER: res = t3 ^ (t3 >> 18);
      default:    res = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/mersenne_twister_generator.sv =====
`default_nettype none
`include "mersenne_twister_generator_defines.svh"

// MT19937 (32-bit) generator. A transaction with func = 0 seeds the 624-word
// state and returns nothing; with func = 1 it returns one tempered word.
// The state sits in a single-port-write, registered-read memory and every
// calculation goes through one shared unit under a small sequencer, so the
// input side takes one transaction at a time. Seeding writes one recurrence
// step per cycle, the multiply by 1812433253 on the chain being the limit.
// An extract runs three memory reads (words k, k+1 and k+397 mod 624), a
// twist of word k written back, then tempering into the output register.
// The twist is done lazily, one word per extract, which returns exactly
// the words of a full-block twist. Before the first seed the state is
// treated as all zero and extracts return zero without touching the
// memory, so no clearing pass follows reset. A finished word waits in the
// output register while the next transaction is accepted; a further
// extract stalls in its last step until it is taken.
module mersenne_twister_generator (
  input  wire         clk,
  input  wire         rst_n,
  mt_in_if.sink       in_chan,
  mt_out_if.source    out_chan
);
  import mt_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_TWIST,
    ST_OUT
  } state_t;

  state_t   state_r, state_nxt;
  logic     seeded_r, seeded_nxt;
  idx_t     idx_r, idx_nxt;       // next word to hand out, 0..623
  idx_t     cnt_r, cnt_nxt;       // seeding position
  word_t    w_r, w_nxt;           // seed chain word / freshly twisted word
  word_t    a_r, a_nxt;           // word k
  word_t    b_r, b_nxt;           // word k+1
  logic     out_valid_r, out_valid_nxt;
  word_t    out_word_r, out_word_nxt;

  idx_t     idx_p1;
  idx_t     idx_pm;
  idx_t     raddr;
  word_t    rdata;
  word_t    alu_res;
  alu_req_t alu_req;
  ram_wr_t  ram_wr;
  logic     in_xact;

  assign in_chan.ready      = (state_r == ST_IDLE);
  assign in_xact            = in_chan.valid && in_chan.ready;
  assign out_chan.valid     = out_valid_r;
  assign out_chan.random_word = out_word_r;

  // neighbour addresses, modulo 624
  assign idx_p1 = (idx_r == LAST_IDX) ? '0 : idx_r + idx_t'(1);
  assign idx_pm = (idx_r >= WRAP_OFS) ? idx_r - WRAP_OFS : idx_r + M_OFS;

  mt_state_ram u_ram (
    .clk   (clk),
    .wr    (ram_wr),
    .raddr (raddr),
    .rdata (rdata)
  );

  mt_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  // read address and shared unit operands per step
  always_comb begin
    case (state_r)
      ST_RD1:  raddr = idx_p1;
      ST_RD2:  raddr = idx_pm;
      default: raddr = idx_r;
    endcase

    alu_req = '{op: ALU_TEMPER, a: w_r, b: b_r, c: rdata, idx: cnt_r};
    case (state_r)
      ST_SEED:  alu_req.op = ALU_SEED;
      ST_TWIST: begin
        alu_req.op = ALU_TWIST;
        alu_req.a  = a_r;
      end
      default:  alu_req.op = ALU_TEMPER;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    seeded_nxt    = seeded_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    w_nxt         = w_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_word_nxt  = out_word_r;
    ram_wr        = '{en: 1'b0, addr: idx_r, data: alu_res};

    case (state_r)
      ST_IDLE: begin
        if (in_xact) begin
          if (!in_chan.func) begin
            // word 0 is the seed itself
            ram_wr     = '{en: 1'b1, addr: '0, data: in_chan.seed_value};
            w_nxt      = in_chan.seed_value;
            cnt_nxt    = idx_t'(1);
            idx_nxt    = '0;
            seeded_nxt = 1'b1;
            state_nxt  = ST_SEED;
          end else if (seeded_r) begin
            state_nxt = ST_RD0;
          end else begin
            // all-zero state: twist keeps it zero, tempered word is zero
            w_nxt     = '0;
            state_nxt = ST_OUT;
          end
        end
      end
      ST_SEED: begin
        ram_wr  = '{en: 1'b1, addr: cnt_r, data: alu_res};
        w_nxt   = alu_res;
        cnt_nxt = cnt_r + idx_t'(1);
        if (cnt_r == LAST_IDX) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RD0: state_nxt = ST_RD1;
      ST_RD1: begin
        a_nxt     = rdata;
        state_nxt = ST_RD2;
      end
      ST_RD2: begin
        b_nxt     = rdata;
        state_nxt = ST_TWIST;
      end
      ST_TWIST: begin
        ram_wr    = '{en: 1'b1, addr: idx_r, data: alu_res};
        w_nxt     = alu_res;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = alu_res;
          idx_nxt       = idx_p1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      seeded_r    <= 1'b0;
      idx_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seeded_r    <= seeded_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    w_r        <= w_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    out_word_r <= out_word_nxt;
  end

  `MT_ASSERT_IMPL(a_idx_range, clk, rst_n, 1'b1, idx_r < IDX_DEPTH, "read index beyond state")
  `MT_ASSERT_IMPL(a_wr_range, clk, rst_n, ram_wr.en, ram_wr.addr < IDX_DEPTH, "state write out of range")
  `MT_ASSERT_IMPL(a_out_src, clk, rst_n, $rose(out_valid_r), $past(state_r == ST_OUT), "result without output step")
  `MT_ASSERT_NEXT(a_seed_len, clk, rst_n, (state_r == ST_SEED) && (cnt_r != LAST_IDX), state_r == ST_SEED, "seeding cut short")

endmodule

`default_nettype wire
